[rtl/tvdfr_pkg.sv]
// Package for the TVD face reconstruction core: types, widths, mode codes and register indexes.
// Used by the core, front, queue and back modules; depends on nothing.
package tvdfr_pkg;
  localparam int VW = 32;
  localparam int FB = 16;
  localparam int MW = VW + 1;
  localparam int PW = 2 * MW;
  localparam int TW = 16;
  localparam int QDEPTH = 4;
  localparam int QAW = 2;

  localparam logic [0:0] REG_SCHEME_MODE = 1'b0;
  localparam logic [0:0] REG_TINY_MAGNITUDE = 1'b1;

  typedef enum logic [1:0] {
    MODE_TVD = 2'd0,
    MODE_UPWIND = 2'd1,
    MODE_CENTRAL = 2'd2,
    MODE_TVD_ALT = 2'd3
  } mode_t;

  typedef struct packed {
    logic signed [VW-1:0] vel;
    logic signed [VW-1:0] base;
    logic                 corr_on;
    logic                 sub;
    logic [MW-1:0]        nm;
    logic [MW-1:0]        dm;
  } job_t;
endpackage

[rtl/tvd_face_reconstruction_core.sv]
// Top level of the TVD face reconstruction core: config registers, front,
// queue and back part. Depends on tvdfr_pkg and the tvdfr_* modules.
//  channel | direction | request payload
//  in_*    | input     | four samples, face velocity, two outer flags
//  out_*   | output    | face value and face flux
// One request enters per cycle while in_stall is low; its result passes through
// the 66-stage one-bit-per-stage limiter divider, then face, product and flux stages.
// Reset is synchronous, active low, and clears the valid pipeline and queue.
// An output stall freezes the back pipeline; the queue then fills and stalls the input.
module tvd_face_reconstruction_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic signed [31:0] in_far_left,
  input  logic signed [31:0] in_left_value,
  input  logic signed [31:0] in_right_value,
  input  logic signed [31:0] in_far_right,
  input  logic signed [31:0] in_face_vel,
  input  logic        in_far_left_valid,
  input  logic        in_far_right_valid,
  output logic        out_valid,
  input  logic        out_stall,
  output logic signed [31:0] out_face_value,
  output logic signed [31:0] out_face_flux
);
  import tvdfr_pkg::*;

  logic [1:0] mode_r;
  logic [TW-1:0] tiny_r;
  logic jv, qfull, qv, qpop;
  job_t jb, qd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_TVD;
      tiny_r <= TW'(1);
    end else if (cfg_we) begin
      if (cfg_index == REG_SCHEME_MODE) mode_r <= cfg_data[1:0];
      else tiny_r <= cfg_data;
    end
  end

  tvdfr_front u_front (.clk, .rst_n, .mode(mode_r), .tiny(tiny_r), .in_valid, .in_stall,
    .in_far_left, .in_left_value, .in_right_value, .in_far_right, .in_face_vel,
    .in_far_left_valid, .in_far_right_valid, .job_valid(jv), .job(jb), .job_full(qfull));

  tvdfr_queue u_queue (.clk, .rst_n, .push(jv), .push_data(jb), .almost_full(qfull),
    .pop_valid(qv), .pop_data(qd), .pop(qpop));

  tvdfr_back u_back (.clk, .rst_n, .job_valid(qv), .job(qd), .job_pop(qpop),
    .out_valid, .out_stall, .out_face_value, .out_face_flux);
endmodule

[rtl/tvdfr_front.sv]
// Front part: accepts one face per cycle while job_full is low, picks the mode path and forms the
// gradient magnitudes for the limiter. Depends on tvdfr_pkg.
module tvdfr_front (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [1:0]                  mode,
  input  logic [tvdfr_pkg::TW-1:0]    tiny,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic signed [tvdfr_pkg::VW-1:0] in_far_left,
  input  logic signed [tvdfr_pkg::VW-1:0] in_left_value,
  input  logic signed [tvdfr_pkg::VW-1:0] in_right_value,
  input  logic signed [tvdfr_pkg::VW-1:0] in_far_right,
  input  logic signed [tvdfr_pkg::VW-1:0] in_face_vel,
  input  logic                        in_far_left_valid,
  input  logic                        in_far_right_valid,
  output logic                        job_valid,
  output tvdfr_pkg::job_t             job,
  input  logic                        job_full
);
  import tvdfr_pkg::*;

  logic signed [MW-1:0] l, r, fl, fr, v, d, n;
  logic [MW-1:0] vm, dmag, nmag;
  logic vpos, vzero, outer_ok, same;
  logic [VW:0] csum;
  logic valid_r, valid_nxt;
  job_t job_r, job_nxt;

  assign in_stall = job_full;

  always_comb begin
    l = MW'(in_left_value);
    r = MW'(in_right_value);
    fl = MW'(in_far_left);
    fr = MW'(in_far_right);
    v = MW'(in_face_vel);
    vpos = !in_face_vel[VW-1];
    vm = vpos ? v : -v;
    vzero = vm < MW'(tiny);
    d = r - l;
    n = vpos ? (l - fl) : (fr - r);
    dmag = d[MW-1] ? -d : d;
    nmag = n[MW-1] ? -n : n;
    same = (d[MW-1] == n[MW-1]);
    outer_ok = vpos ? in_far_left_valid : in_far_right_valid;
    csum = {in_left_value[VW-1], in_left_value} + {in_right_value[VW-1], in_right_value};
    job_nxt.vel = in_face_vel;
    job_nxt.nm = nmag;
    job_nxt.dm = dmag;
    job_nxt.sub = d[MW-1];
    job_nxt.corr_on = 1'b0;
    job_nxt.base = vpos ? in_left_value : in_right_value;
    if (mode == MODE_CENTRAL) begin
      job_nxt.base = csum[VW:1];
    end else if (mode != MODE_UPWIND && !vzero && outer_ok) begin
      job_nxt.corr_on = same && nmag != '0 && dmag != '0 && !(dmag < MW'(tiny));
    end
    valid_nxt = in_valid && !job_full;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    job_r <= job_nxt;
  end

  assign job_valid = valid_r;
  assign job = job_r;
endmodule

[rtl/tvdfr_queue.sv]
// Short queue between front and back parts of the reconstruction core.
// Depends on tvdfr_pkg.
module tvdfr_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  tvdfr_pkg::job_t push_data,
  output logic            almost_full,
  output logic            pop_valid,
  output tvdfr_pkg::job_t pop_data,
  input  logic            pop
);
  import tvdfr_pkg::*;

  job_t mem [QDEPTH];
  logic [QAW-1:0] wp_r, rp_r;
  logic [QAW:0] cnt_r, cnt_nxt;
  logic do_pop;

  assign do_pop = pop && cnt_r != '0;
  assign pop_valid = cnt_r != '0;
  assign pop_data = mem[rp_r];
  assign cnt_nxt = cnt_r + (QAW+1)'(push) - (QAW+1)'(do_pop);
  assign almost_full = cnt_r >= (QAW+1)'(QDEPTH - 2);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (do_pop) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_nxt;
    end
    if (push) mem[wp_r] <= push_data;
  end
endmodule

[rtl/tvdfr_back.sv]
// Back part: pipelined limiter division n*d/(n+d), face value and flux.
// Depends on tvdfr_pkg.
module tvdfr_back (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   job_valid,
  input  tvdfr_pkg::job_t        job,
  output logic                   job_pop,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic signed [tvdfr_pkg::VW-1:0] out_face_value,
  output logic signed [tvdfr_pkg::VW-1:0] out_face_flux
);
  import tvdfr_pkg::*;

  localparam int NST = 3 + PW;
  localparam int SW = MW + 1;

  logic adv;
  logic [NST-1:0] v_r;
  logic [PW-1:0] p_r [PW+1];
  logic [SW:0] rem_r [PW+1];
  logic [PW-1:0] q_r [PW+1];
  logic [SW-1:0] s_r [PW+1];
  job_t j_r [PW+1];
  logic signed [VW-1:0] face_r, f2_r, vel2_r;
  logic signed [VW-1:0] face_c;
  logic [VW-1:0] c;
  logic [MW-1:0] vm, fm;
  logic neg3_r;
  logic [2*VW-1:0] prod_r;
  logic [2*VW-1:0] pr;
  logic [2*VW-1:0] sh;
  logic [VW-1:0] m;
  logic [VW-1:0] lim;
  logic signed [VW-1:0] flux;
  logic signed [VW-1:0] fo_r, fv_r;
  logic ov_r;

  assign adv = !ov_r || !out_stall;
  assign job_pop = adv && job_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
      ov_r <= 1'b0;
    end else if (adv) begin
      v_r <= {v_r[NST-2:0], job_valid};
      ov_r <= v_r[NST-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      j_r[0] <= job;
      p_r[0] <= PW'(job.nm[VW-1:0]) * PW'(job.dm[VW-1:0]);
      s_r[0] <= SW'(job.nm) + SW'(job.dm);
      rem_r[0] <= '0;
      q_r[0] <= '0;
      for (int i = 0; i < PW; i++) begin
        j_r[i+1] <= j_r[i];
        s_r[i+1] <= s_r[i];
        p_r[i+1] <= {p_r[i][PW-2:0], 1'b0};
        if ({rem_r[i][SW-1:0], p_r[i][PW-1]} >= {1'b0, s_r[i]}) begin
          rem_r[i+1] <= {rem_r[i][SW-1:0], p_r[i][PW-1]} - {1'b0, s_r[i]};
          q_r[i+1] <= {q_r[i][PW-2:0], 1'b1};
        end else begin
          rem_r[i+1] <= {rem_r[i][SW-1:0], p_r[i][PW-1]};
          q_r[i+1] <= {q_r[i][PW-2:0], 1'b0};
        end
      end
      face_r <= face_c;
      vel2_r <= j_r[PW].vel;
      neg3_r <= vm[MW-1] ^ fm[MW-1];
      prod_r <= (2*VW)'(vm[VW-1:0]) * (2*VW)'(fm[VW-1:0]);
      f2_r <= face_r;
      fo_r <= f2_r;
      fv_r <= flux;
    end
  end

  always_comb begin
    c = j_r[PW].corr_on ? q_r[PW][VW-1:0] : '0;
    if (j_r[PW].sub) begin
      face_c = j_r[PW].vel[VW-1] ? (j_r[PW].base + $signed(c)) : (j_r[PW].base - $signed(c));
    end else begin
      face_c = j_r[PW].vel[VW-1] ? (j_r[PW].base - $signed(c)) : (j_r[PW].base + $signed(c));
    end
    vm = {vel2_r[VW-1], vel2_r[VW-1] ? VW'(-vel2_r) : vel2_r};
    fm = {face_r[VW-1], face_r[VW-1] ? VW'(-face_r) : face_r};
    pr = prod_r + (neg3_r ? (2*VW)'((64'd1 << FB) - 1) : '0);
    sh = pr >> FB;
    lim = neg3_r ? VW'(64'd1 << (VW-1)) : VW'((64'd1 << (VW-1)) - 1);
    m = (sh > (2*VW)'(lim)) ? lim : sh[VW-1:0];
    flux = neg3_r ? VW'(-m) : m;
  end

  assign out_valid = ov_r;
  assign out_face_value = fo_r;
  assign out_face_flux = fv_r;
endmodule

[rtl/tvdfr_checker.sv]
// Port checker for the reconstruction core, bound to the top level.
// Depends only on the top level's ports.
module tvdfr_checker (
  input logic clk,
  input logic rst_n,
  input logic out_valid,
  input logic out_stall,
  input logic [31:0] out_face_value,
  input logic [31:0] out_face_flux
);
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_face_value)) else $error("hold");
  a_flux: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_face_flux)) else $error("flux");
  a_rst: assert property (@(posedge clk) !rst_n |=> !out_valid) else $error("reset");
endmodule

bind tvd_face_reconstruction_core tvdfr_checker u_chk (.clk, .rst_n, .out_valid,
  .out_stall, .out_face_value, .out_face_flux);
